/* hdl/hgrm_pkg.sv */
// Shared constants, types and codes for the height grid running mean block.
`default_nettype none
package hgrm_pkg;

    // grid geometry and count width
    localparam int GRID_COLS  = 64;
    localparam int GRID_ROWS  = 64;
    localparam int COUNT_BITS = 16;

    localparam int COL_W  = $clog2(GRID_COLS);
    localparam int ROW_W  = $clog2(GRID_ROWS);
    localparam int NCELLS = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W = $clog2(NCELLS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // field widths
    localparam int POS_W   = 24;
    localparam int Z_W     = 20;
    localparam int MEAN_W  = 24;
    localparam int VAR_W   = 39;
    localparam int OCNT_W  = 16;
    localparam int SUM_W   = Z_W + COUNT_BITS + 1;
    localparam int SQ_W    = 2 * Z_W - 2 + COUNT_BITS;
    localparam int ZSQ_W   = 2 * Z_W - 1;

    // shared shift/add/subtract unit
    localparam int ALU_W   = SQ_W + COUNT_BITS + 2;
    localparam int DEN_W   = (2 * COUNT_BITS > 16) ? 2 * COUNT_BITS : 16;
    localparam int CNT_W   = $clog2(ALU_W + 1);
    localparam int POS_IT  = POS_W + 1;
    localparam int MEAN_IT = MEAN_W + COUNT_BITS + 1;
    localparam int NUM_W   = MEAN_IT + 1;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_QPOS   = 2'd1,
        FUNC_QCELL  = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        CFG_X_ORG  = 3'd0,
        CFG_Y_ORG  = 3'd1,
        CFG_CSIZE  = 3'd2,
        CFG_FILT   = 3'd3,
        CFG_Z_LOW  = 3'd4,
        CFG_Z_HIGH = 3'd5
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOCX,
        ST_LOCX_W,
        ST_LOCY,
        ST_LOCY_W,
        ST_READ,
        ST_READ_W,
        ST_UPD,
        ST_MMUL,
        ST_MMUL_W,
        ST_MDIV,
        ST_MDIV_W,
        ST_PMUL,
        ST_PMUL_W,
        ST_SMUL,
        ST_SMUL_W,
        ST_DMUL,
        ST_DMUL_W,
        ST_VDIV,
        ST_VDIV_W,
        ST_WRITE,
        ST_DONE
    } t_state;

    // one grid cell as stored in memory
    typedef struct packed {
        logic [VAR_W-1:0]             var_mm2;
        logic [SQ_W-1:0]              sumsq;
        logic signed [SUM_W-1:0]      sum;
        logic signed [MEAN_W-1:0]     mean;
        logic [COUNT_BITS-1:0]        count;
    } t_cell;

    localparam int CELL_W = $bits(t_cell);

    // request to the shared unit: shift-add multiply or restoring divide
    typedef struct packed {
        logic              mul;
        logic [ALU_W-1:0]  a;
        logic [ALU_W-1:0]  b;
        logic [CNT_W-1:0]  cnt;
    } t_alu_req;

endpackage
`default_nettype wire

/* hdl/hgrm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hgrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]                o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* hdl/hgrm_alu.sv */
// Shared iterative unit: shift-add multiply or restoring divide, one bit per cycle.
`default_nettype none
module hgrm_alu (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire hgrm_pkg::t_alu_req      i_req,
    output logic                         o_done,
    output logic [hgrm_pkg::ALU_W-1:0]   o_res
);
    import hgrm_pkg::*;

    logic             r_run, n_run;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_mul, n_mul;
    logic [ALU_W-1:0] r_x, n_x;     // multiplicand / dividend-quotient
    logic [ALU_W-1:0] r_y, n_y;     // multiplier / divisor
    logic [ALU_W-1:0] r_acc, n_acc; // product / remainder
    logic [DEN_W:0]   trial;
    logic             ge;

    always_comb begin
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_mul  = r_mul;
        n_x    = r_x;
        n_y    = r_y;
        n_acc  = r_acc;
        trial  = {r_acc[DEN_W-1:0], r_x[ALU_W-1]};
        ge     = trial >= {1'b0, r_y[DEN_W-1:0]};
        if (i_start) begin
            n_run = 1'b1;
            n_cnt = i_req.cnt;
            n_mul = i_req.mul;
            n_x   = i_req.a;
            n_y   = i_req.b;
            n_acc = '0;
        end else if (r_run) begin
            if (r_mul) begin
                if (r_y[0]) begin
                    n_acc = r_acc + r_x;
                end
                n_x = {r_x[ALU_W-2:0], 1'b0};
                n_y = {1'b0, r_y[ALU_W-1:1]};
            end else begin
                n_acc = ALU_W'(ge ? trial - {1'b0, r_y[DEN_W-1:0]} : trial);
                n_x   = {r_x[ALU_W-2:0], ge};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_mul <= n_mul;
        r_x   <= n_x;
        r_y   <= n_y;
        r_acc <= n_acc;
    end

    assign o_done = r_done;
    assign o_res  = r_mul ? r_acc : r_x;
endmodule
`default_nettype wire

/* hdl/height_grid_running_mean.sv */
// Height grid with per-cell running mean and variance: sequencer and top level.
//
// Usage:
//  - Input beats on the s-side stream: tuser carries the function (insert,
//    query by position, query by cell, clear), tdata the point and cell index.
//  - Every input beat gives exactly one result beat on the m-side stream.
//  - Registers are written on the cfg channel (always ready) by the user
//    only while idle; the block itself does not enforce this.
// Operation (one item at a time, s-side ready only while idle):
//  - query by position: two 25-step divisions in the shared shift/subtract unit.
//  - insert: the shared unit works, one bit a cycle, |mean|*W, the rounded
//    mean division, n*sumsq, sum^2, n*W and the exact variance division;
//    filtered or saturated points and a cell's first point finish early.
//  - clear: a sweep over all NCELLS cells (4096) of the cell memory.
// Reset: a clearing pass over all NCELLS cells zeroes the cell memory; no
// input beat is taken meanwhile, cfg writes are.
// Stall: the result waits in an output register; the next item can be
// accepted and worked on, and the sequencer holds before delivery until
// the output register is free.
`default_nettype none
module height_grid_running_mean (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // tdata: pos_x_mm[23:0], pos_y_mm[47:24], height_mm[67:48],
    //        cell_col[73:68], cell_row[79:74]
    input  wire logic [79:0]  i_s_tdata,
    input  wire logic [1:0]   i_s_tuser,    // tuser: func[1:0]
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // tdata: in_map[0], observed[1], mean_height_q4[25:2],
    //        variance_mm2[64:26], point_count[80:65], zero[87:81]
    output logic [87:0]       o_m_tdata,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [23:0]  i_cfg_data
);
    import hgrm_pkg::*;

    localparam int OUT_W = 88;

    // config registers
    logic signed [POS_W-1:0] r_x_org, r_y_org;
    logic [15:0]             r_csize;
    logic                    r_filt;
    logic signed [Z_W-1:0]   r_zlo, r_zhi;

    // sequencer state
    t_state                  r_state, n_state;
    logic [ADDR_W-1:0]       r_clr_addr, n_clr_addr;
    logic                    r_clr_out, n_clr_out;
    logic                    r_out_valid, n_out_valid;
    logic [OUT_W-1:0]        r_out_data, n_out_data;

    // item payload and working registers
    t_func                   r_func, n_func;
    logic signed [POS_W-1:0] r_x, n_x, r_y, n_y;
    logic signed [Z_W-1:0]   r_z, n_z;
    logic                    r_dneg, n_dneg;
    logic [COL_W-1:0]        r_col, n_col;
    logic [ROW_W-1:0]        r_row, n_row;
    logic                    r_inside, n_inside;
    logic [ADDR_W-1:0]       r_addr, n_addr;
    t_cell                   r_cell, n_cell;
    logic [ZSQ_W-1:0]        r_zsq, n_zsq;
    logic signed [NUM_W-1:0] r_num, n_num;
    logic [ALU_W-1:0]        r_p, n_p, r_s, n_s;
    logic [DEN_W-1:0]        r_den, n_den;

    // unit and memory hookup
    logic                    alu_start;
    t_alu_req                alu_req;
    logic                    alu_done;
    logic [ALU_W-1:0]        alu_res;
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
    logic [CELL_W-1:0]       ram_wdata, ram_rdata;

    // combinational helpers
    logic signed [POS_W:0]   diff;
    logic [POS_W:0]          dmag;
    logic [15:0]             size_eff;
    logic [POS_IT-1:0]       pq;
    logic                    pos_ok;
    logic [ADDR_W-1:0]       addr;
    logic signed [2*Z_W-1:0] zz;
    logic                    filt_drop;
    logic [MEAN_W-1:0]       mabs, mneg;
    logic [MEAN_IT-1:0]      prod, numabs, nnum, mq, mqn;
    logic signed [NUM_W-1:0] sprod, z16;
    logic [COUNT_BITS-1:0]   cnt_m1;
    logic [SUM_W-1:0]        sabs, sneg;
    logic [31:0]             cnt32;
    logic [OCNT_W-1:0]       pc;
    logic [MEAN_W-1:0]       o_mean;
    logic [VAR_W-1:0]        o_var;

    hgrm_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (alu_start),
        .i_req   (alu_req),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    hgrm_ram #(.WIDTH(CELL_W), .DEPTH(NCELLS)) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // config writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_org <= '0;
            r_y_org <= '0;
            r_csize <= 16'd100;
            r_filt  <= 1'b0;
            r_zlo   <= {1'b1, {(Z_W-1){1'b0}}};
            r_zhi   <= {1'b0, {(Z_W-1){1'b1}}};
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_X_ORG:  r_x_org <= i_cfg_data;
                CFG_Y_ORG:  r_y_org <= i_cfg_data;
                CFG_CSIZE:  r_csize <= i_cfg_data[15:0];
                CFG_FILT:   r_filt  <= i_cfg_data[0];
                CFG_Z_LOW:  r_zlo   <= i_cfg_data[Z_W-1:0];
                CFG_Z_HIGH: r_zhi   <= i_cfg_data[Z_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_comb begin
        // shared helpers
        size_eff  = (r_csize == 16'd0) ? 16'd1 : r_csize;
        diff      = (r_state == ST_LOCX) ? (POS_W+1)'(r_x) - (POS_W+1)'(r_x_org)
                                         : (POS_W+1)'(r_y) - (POS_W+1)'(r_y_org);
        dmag      = diff[POS_W] ? (POS_W+1)'(-diff) : (POS_W+1)'(diff);
        pq        = alu_res[POS_IT-1:0];
        pos_ok    = r_dneg ? (pq == '0)
                           : (pq < ((r_state == ST_LOCX_W) ? POS_IT'(GRID_COLS)
                                                           : POS_IT'(GRID_ROWS)));
        addr      = ADDR_W'(32'(r_row) * 32'(GRID_COLS) + 32'(r_col));
        zz        = r_z * r_z;
        filt_drop = r_filt && ((r_z < r_zlo) || (r_z > r_zhi));
        mneg      = MEAN_W'(0) - r_cell.mean;
        mabs      = r_cell.mean[MEAN_W-1] ? mneg : r_cell.mean;
        prod      = alu_res[MEAN_IT-1:0];
        sprod     = r_cell.mean[MEAN_W-1] ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
        z16       = NUM_W'(r_z) <<< 4;
        nnum      = MEAN_IT'(0) - r_num[MEAN_IT-1:0];
        numabs    = r_num[NUM_W-1] ? nnum : r_num[MEAN_IT-1:0];
        mq        = alu_res[MEAN_IT-1:0];
        mqn       = MEAN_IT'(0) - mq;
        cnt_m1    = r_cell.count - COUNT_BITS'(1);
        sneg      = SUM_W'(0) - r_cell.sum;
        sabs      = r_cell.sum[SUM_W-1] ? sneg : r_cell.sum;
        cnt32     = 32'(r_cell.count);
        pc        = (cnt32 > 32'hFFFF) ? 16'hFFFF : cnt32[15:0];
        o_mean    = r_inside ? r_cell.mean : '0;
        o_var     = r_inside ? r_cell.var_mm2 : '0;

        // defaults
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_clr_out   = r_clr_out;
        n_out_valid = (r_out_valid && i_m_tready) ? 1'b0 : r_out_valid;
        n_out_data  = r_out_data;
        n_func      = r_func;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_dneg      = r_dneg;
        n_col       = r_col;
        n_row       = r_row;
        n_inside    = r_inside;
        n_addr      = r_addr;
        n_cell      = r_cell;
        n_zsq       = r_zsq;
        n_num       = r_num;
        n_p         = r_p;
        n_s         = r_s;
        n_den       = r_den;
        alu_start   = 1'b0;
        alu_req     = '0;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = r_cell;
        ram_raddr   = r_addr;

        unique case (r_state) inside
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(NCELLS - 1)) begin
                    n_clr_addr = '0;
                    n_state    = r_clr_out ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_func = t_func'(i_s_tuser);
                    n_x    = i_s_tdata[23:0];
                    n_y    = i_s_tdata[47:24];
                    n_z    = i_s_tdata[67:48];
                    n_col  = COL_W'(i_s_tdata[73:68]);
                    n_row  = ROW_W'(i_s_tdata[79:74]);
                    unique case (t_func'(i_s_tuser))
                        FUNC_CLEAR: begin
                            n_inside  = 1'b0;
                            n_clr_out = 1'b1;
                            n_state   = ST_CLEAR;
                        end
                        FUNC_QCELL: begin
                            n_inside = (32'(i_s_tdata[73:68]) < 32'(GRID_COLS))
                                    && (32'(i_s_tdata[79:74]) < 32'(GRID_ROWS));
                            n_state  = ((32'(i_s_tdata[73:68]) < 32'(GRID_COLS))
                                    && (32'(i_s_tdata[79:74]) < 32'(GRID_ROWS)))
                                     ? ST_READ : ST_DONE;
                        end
                        default: n_state = ST_LOCX;
                    endcase
                end
            end
            ST_LOCX, ST_LOCY: begin
                alu_start   = 1'b1;
                alu_req.mul = 1'b0;
                alu_req.a   = ALU_W'(dmag) << (ALU_W - POS_IT);
                alu_req.b   = ALU_W'(size_eff);
                alu_req.cnt = CNT_W'(POS_IT);
                n_dneg      = diff[POS_W];
                n_zsq       = zz[ZSQ_W-1:0];
                n_state     = (r_state == ST_LOCX) ? ST_LOCX_W : ST_LOCY_W;
            end
            ST_LOCX_W: begin
                if (alu_done) begin
                    n_inside = pos_ok;
                    n_col    = r_dneg ? '0 : COL_W'(pq);
                    n_state  = ST_LOCY;
                end
            end
            ST_LOCY_W: begin
                if (alu_done) begin
                    n_inside = r_inside && pos_ok;
                    n_row    = r_dneg ? '0 : ROW_W'(pq);
                    n_state  = (r_inside && pos_ok) ? ST_READ : ST_DONE;
                end
            end
            ST_READ: begin
                ram_raddr = addr;
                n_addr    = addr;
                n_state   = ST_READ_W;
            end
            ST_READ_W: begin
                n_cell  = t_cell'(ram_rdata);
                n_state = (r_func == FUNC_INSERT) ? ST_UPD : ST_DONE;
            end
            ST_UPD: begin
                if (filt_drop || (r_cell.count == COUNT_MAX)) begin
                    n_state = ST_DONE;
                end else begin
                    n_cell.count = r_cell.count + COUNT_BITS'(1);
                    n_cell.sum   = r_cell.sum + SUM_W'(r_z);
                    n_cell.sumsq = r_cell.sumsq + SQ_W'(r_zsq);
                    if (r_cell.count == '0) begin
                        n_cell.mean = MEAN_W'(r_z) <<< 4;
                        n_state     = ST_WRITE;
                    end else begin
                        n_state = ST_MMUL;
                    end
                end
            end
            ST_MMUL: begin
                // |mean| * W, W = n - 1
                alu_start   = 1'b1;
                alu_req.mul = 1'b1;
                alu_req.a   = ALU_W'(mabs);
                alu_req.b   = ALU_W'(cnt_m1);
                alu_req.cnt = CNT_W'(COUNT_BITS);
                n_state     = ST_MMUL_W;
            end
            ST_MMUL_W: begin
                if (alu_done) begin
                    n_num   = sprod + z16;
                    n_state = ST_MDIV;
                end
            end
            ST_MDIV: begin
                // round half away from zero on the magnitude
                alu_start   = 1'b1;
                alu_req.mul = 1'b0;
                alu_req.a   = ALU_W'(numabs + MEAN_IT'(r_cell.count >> 1))
                              << (ALU_W - MEAN_IT);
                alu_req.b   = ALU_W'(r_cell.count);
                alu_req.cnt = CNT_W'(MEAN_IT);
                n_state     = ST_MDIV_W;
            end
            ST_MDIV_W: begin
                if (alu_done) begin
                    n_cell.mean = r_num[NUM_W-1] ? mqn[MEAN_W-1:0] : mq[MEAN_W-1:0];
                    n_state     = ST_PMUL;
                end
            end
            ST_PMUL: begin
                alu_start   = 1'b1;
                alu_req.mul = 1'b1;
                alu_req.a   = ALU_W'(r_cell.sumsq);
                alu_req.b   = ALU_W'(r_cell.count);
                alu_req.cnt = CNT_W'(COUNT_BITS);
                n_state     = ST_PMUL_W;
            end
            ST_PMUL_W: begin
                if (alu_done) begin
                    n_p     = alu_res;
                    n_state = ST_SMUL;
                end
            end
            ST_SMUL: begin
                alu_start   = 1'b1;
                alu_req.mul = 1'b1;
                alu_req.a   = ALU_W'(sabs);
                alu_req.b   = ALU_W'(sabs);
                alu_req.cnt = CNT_W'(SUM_W);
                n_state     = ST_SMUL_W;
            end
            ST_SMUL_W: begin
                if (alu_done) begin
                    n_s     = alu_res;
                    n_state = ST_DMUL;
                end
            end
            ST_DMUL: begin
                alu_start   = 1'b1;
                alu_req.mul = 1'b1;
                alu_req.a   = ALU_W'(r_cell.count);
                alu_req.b   = ALU_W'(cnt_m1);
                alu_req.cnt = CNT_W'(COUNT_BITS);
                n_state     = ST_DMUL_W;
            end
            ST_DMUL_W: begin
                if (alu_done) begin
                    n_den   = alu_res[DEN_W-1:0];
                    n_state = ST_VDIV;
                end
            end
            ST_VDIV: begin
                // floor((n*sumsq - sum^2) / (n*W)), exact
                alu_start   = 1'b1;
                alu_req.mul = 1'b0;
                alu_req.a   = r_p - r_s;
                alu_req.b   = ALU_W'(r_den);
                alu_req.cnt = CNT_W'(ALU_W);
                n_state     = ST_VDIV_W;
            end
            ST_VDIV_W: begin
                if (alu_done) begin
                    n_cell.var_mm2 = alu_res[VAR_W-1:0];
                    n_state        = ST_WRITE;
                end
            end
            ST_WRITE: begin
                ram_we  = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = OUT_W'({(r_inside ? pc : 16'd0), o_var, o_mean,
                                          (r_inside && (r_cell.count != '0)),
                                          r_inside});
                    n_clr_out   = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_clr_out   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_out   <= n_clr_out;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_func     <= n_func;
        r_x        <= n_x;
        r_y        <= n_y;
        r_z        <= n_z;
        r_dneg     <= n_dneg;
        r_col      <= n_col;
        r_row      <= n_row;
        r_inside   <= n_inside;
        r_addr     <= n_addr;
        r_cell     <= n_cell;
        r_zsq      <= n_zsq;
        r_num      <= n_num;
        r_p        <= n_p;
        r_s        <= n_s;
        r_den      <= n_den;
    end

`ifndef SYNTH
    // the shared unit only reports completion while the sequencer waits on it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_done |-> (r_state == ST_LOCX_W || r_state == ST_LOCY_W ||
                      r_state == ST_MMUL_W || r_state == ST_MDIV_W ||
                      r_state == ST_PMUL_W || r_state == ST_SMUL_W ||
                      r_state == ST_DMUL_W || r_state == ST_VDIV_W))
        else $error("shared unit finished outside a wait state");

    // a clearing pass leaves only after sweeping the last cell
    a_clear_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR && n_state != ST_CLEAR)
            |-> r_clr_addr == ADDR_W'(NCELLS - 1))
        else $error("clearing pass ended early");

    // no cell write while idle
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !ram_we)
        else $error("cell memory written while idle");
`endif

endmodule
`default_nettype wire
